/* design/chunked_blob_receiver_fnv1a_check_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the chunked blob receiver
// Same-cycle and next-cycle implication checks, clocked on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_BLOB_RECEIVER_FNV1A_CHECK_TOP_ASSERT_SVH
`define CHUNKED_BLOB_RECEIVER_FNV1A_CHECK_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CBR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define CBR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/cbr_pkg.sv */
// ----------------------------------------------------------------------------
// cbr_pkg
// Types, codes and sizes shared by the chunked blob receiver.
// ----------------------------------------------------------------------------
package cbr_pkg;

   localparam int MAX_BLOB_BYTES = 4096;
   localparam int CHUNK_BYTES    = 64;
   localparam int MAX_CHUNKS     = (MAX_BLOB_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;

   localparam int BUF_ADDR_W  = $clog2(MAX_BLOB_BYTES);
   localparam int SIZE_W      = $clog2(MAX_BLOB_BYTES + 1);
   localparam int CHUNK_CNT_W = $clog2(MAX_CHUNKS + 1);
   localparam int CHUNK_IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   // request codes
   localparam logic [1:0] REQ_DATA   = 2'd0;
   localparam logic [1:0] REQ_COMMIT = 2'd1;
   localparam logic [1:0] REQ_BEGIN  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_CHUNK  = 2'd0;
   localparam logic [1:0] KIND_COMMIT = 2'd1;
   localparam logic [1:0] KIND_BEGIN  = 2'd2;

   // commit status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_BAD_HASH = 2'd1;
   localparam logic [1:0] STAT_BAD_SIZE = 2'd2;

   // session modes
   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_OPEN = 2'd1;
   localparam logic [1:0] MODE_DONE = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] request_hash;
      logic [15:0] total_size;
      logic [15:0] total_chunks;
      logic [15:0] chunk_index;
      logic [15:0] chunk_offset;
      logic [7:0]  chunk_size;
      logic [7:0]  byte_pos;
      logic [7:0]  data_byte;
      logic        last_byte;
   } cbr_req_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic       accepted;
      logic [1:0] commit_status;
   } cbr_rsp_type;

endpackage

/* design/cbr_fnv_core.sv */
// ----------------------------------------------------------------------------
// cbr_fnv_core
// FNV-1a accumulator: one byte folded in per step through a 32x32 multiply.
// ----------------------------------------------------------------------------
module cbr_fnv_core (
   input  logic        clock,
   input  logic        init,
   input  logic        step,
   input  logic [7:0]  byte_in,
   output logic [31:0] hash
);
   import cbr_pkg::*;

   logic [31:0] hash_ff;
   logic [31:0] hash_in;

   always_comb begin
      hash_in = hash_ff;
      if (init) begin
         hash_in = FNV_BASIS;
      end else if (step) begin
         hash_in = (hash_ff ^ {24'd0, byte_in}) * FNV_PRIME;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
   end

   assign hash = hash_ff;

endmodule

/* design/chunked_blob_receiver_fnv1a_check_top.sv */
// ----------------------------------------------------------------------------
// chunked_blob_receiver_fnv1a_check_top
// Chunked blob reassembly into a 4 KiB buffer with an FNV-1a commit check.
// ----------------------------------------------------------------------------
// Usage:
//   A request on req_data is taken at a clock edge with start high and busy
//   low. Results come out on rsp_data for one cycle, flagged by rsp_valid;
//   the receiver takes every result and cannot stall it.
//   Data byte: taken with busy staying low, so a chunk streams in at
//   one byte per cycle. Only the last byte of a chunk gives a chunk ack,
//   in the cycle after its transfer.
//   Begin: ack in the next cycle. A good begin then clears the 4096-byte
//   buffer one byte per cycle through its single write port: busy is high
//   throughout the pass.
//   Commit: a commit that fails the session, hash or chunk-map check, or
//   whose session is already committed, is answered in the next cycle.
//   Otherwise the hash unit reads the buffer one byte per cycle and
//   multiplies once per byte; busy stays high until the status appears.
//   Request type 3 is taken and gives no result.
//   Reset: the session closes and the buffer is cleared by the same
//   clearing pass, busy high throughout.
// ----------------------------------------------------------------------------
`include "chunked_blob_receiver_fnv1a_check_top_assert.svh"

module chunked_blob_receiver_fnv1a_check_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  cbr_pkg::cbr_req_type req_data,
   output logic                rsp_valid,
   output cbr_pkg::cbr_rsp_type rsp_data
);
   import cbr_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH
   } state_type;

   localparam logic [BUF_ADDR_W-1:0] ADDR_LAST = BUF_ADDR_W'(MAX_BLOB_BYTES - 1);

   state_type               state_ff, state_in;
   logic [1:0]              mode_ff, mode_in;
   logic [31:0]             exp_hash_ff, exp_hash_in;
   logic [SIZE_W-1:0]       exp_size_ff, exp_size_in;
   logic [CHUNK_CNT_W-1:0]  exp_chunks_ff, exp_chunks_in;
   logic [MAX_CHUNKS-1:0]   seen_ff, seen_in;
   logic [SIZE_W-1:0]       cnt_ff, cnt_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   cbr_rsp_type             rsp_ff, rsp_in;

   logic [7:0]              mem [MAX_BLOB_BYTES];
   logic [7:0]              rd_data_ff;
   logic                    mem_we;
   logic [BUF_ADDR_W-1:0]   mem_waddr;
   logic [7:0]              mem_wdata;

   logic                    accept;
   logic                    chunk_ok;
   logic                    byte_store;
   logic [15:0]             room;
   logic [16:0]             byte_addr;
   logic                    begin_ok;
   logic [MAX_CHUNKS-1:0]   need_mask;
   logic                    all_seen;
   logic                    fnv_init;
   logic                    fnv_step;
   logic [31:0]             fnv_hash;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // chunk checks against the open session
   assign room      = 16'(exp_size_ff) - req_data.chunk_offset;
   assign byte_addr = {1'b0, req_data.chunk_offset} + {9'd0, req_data.byte_pos};
   assign chunk_ok  = (mode_ff == MODE_OPEN)
                   && (req_data.request_hash == exp_hash_ff)
                   && (req_data.chunk_index < 16'(exp_chunks_ff))
                   && (req_data.chunk_size != 8'd0)
                   && (req_data.chunk_size <= 8'(CHUNK_BYTES))
                   && (req_data.chunk_offset <= 16'(exp_size_ff))
                   && (16'(req_data.chunk_size) <= room);
   assign byte_store = chunk_ok && (req_data.byte_pos < req_data.chunk_size)
                    && (byte_addr < 17'(MAX_BLOB_BYTES));

   assign begin_ok = (req_data.total_size != 16'd0)
                  && (req_data.total_size <= 16'(MAX_BLOB_BYTES))
                  && (req_data.total_chunks != 16'd0)
                  && (req_data.total_chunks <= 16'(MAX_CHUNKS));

   always_comb begin
      for (int i = 0; i < MAX_CHUNKS; i++) begin
         need_mask[i] = (CHUNK_CNT_W'(i) < exp_chunks_ff);
      end
   end
   assign all_seen = ((seen_ff & need_mask) == need_mask);

   // buffer write port: clear pass or an incoming byte
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff[BUF_ADDR_W-1:0];
      mem_wdata = 8'd0;
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
      end else if (accept && req_data.req_type == REQ_DATA && byte_store) begin
         mem_we    = 1'b1;
         mem_waddr = byte_addr[BUF_ADDR_W-1:0];
         mem_wdata = req_data.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[cnt_ff[BUF_ADDR_W-1:0]];
   end

   assign fnv_init = accept && (req_data.req_type == REQ_COMMIT);
   assign fnv_step = (state_ff == ST_HASH) && rd_valid_ff;

   cbr_fnv_core u_fnv (
      .clock   (clock),
      .init    (fnv_init),
      .step    (fnv_step),
      .byte_in (rd_data_ff),
      .hash    (fnv_hash)
   );

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      exp_hash_in   = exp_hash_ff;
      exp_size_in   = exp_size_ff;
      exp_chunks_in = exp_chunks_ff;
      seen_in       = seen_ff;
      cnt_in        = cnt_ff;
      rd_valid_in   = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[BUF_ADDR_W-1:0] == ADDR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               case (req_data.req_type)
                  REQ_DATA: begin
                     if (req_data.last_byte) begin
                        if (chunk_ok) begin
                           seen_in[req_data.chunk_index[CHUNK_IDX_W-1:0]] = 1'b1;
                        end
                        rsp_valid_in         = 1'b1;
                        rsp_in.result_kind   = KIND_CHUNK;
                        rsp_in.accepted      = chunk_ok;
                        rsp_in.commit_status = STAT_OK;
                     end
                  end
                  REQ_COMMIT: begin
                     rsp_in.result_kind = KIND_COMMIT;
                     if (mode_ff == MODE_NONE || req_data.request_hash != exp_hash_ff) begin
                        rsp_valid_in         = 1'b1;
                        rsp_in.commit_status = STAT_BAD_HASH;
                     end else if (mode_ff == MODE_DONE) begin
                        rsp_valid_in         = 1'b1;
                        rsp_in.commit_status = STAT_OK;
                     end else if (!all_seen) begin
                        rsp_valid_in         = 1'b1;
                        rsp_in.commit_status = STAT_BAD_SIZE;
                     end else begin
                        state_in = ST_HASH;
                        cnt_in   = '0;
                     end
                  end
                  REQ_BEGIN: begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.result_kind = KIND_BEGIN;
                     rsp_in.accepted    = begin_ok;
                     if (begin_ok) begin
                        mode_in       = MODE_OPEN;
                        exp_hash_in   = req_data.request_hash;
                        exp_size_in   = SIZE_W'(req_data.total_size);
                        exp_chunks_in = CHUNK_CNT_W'(req_data.total_chunks);
                        seen_in       = '0;
                        state_in      = ST_CLEAR;
                        cnt_in        = '0;
                     end else begin
                        mode_in = MODE_NONE;
                     end
                  end
                  default: begin
                     // unused request code: drop
                  end
               endcase
            end
         end
         ST_HASH: begin
            if (cnt_ff != exp_size_ff) begin
               // issue the next buffer read
               cnt_in      = cnt_ff + 1'b1;
               rd_valid_in = 1'b1;
            end else if (!rd_valid_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_in.result_kind = KIND_COMMIT;
               state_in           = ST_IDLE;
               if (fnv_hash == exp_hash_ff) begin
                  mode_in              = MODE_DONE;
                  rsp_in.commit_status = STAT_OK;
               end else begin
                  mode_in              = MODE_NONE;
                  rsp_in.commit_status = STAT_BAD_HASH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         mode_ff       <= MODE_NONE;
         exp_hash_ff   <= '0;
         exp_size_ff   <= '0;
         exp_chunks_ff <= '0;
         seen_ff       <= '0;
         cnt_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         exp_hash_ff   <= exp_hash_in;
         exp_size_ff   <= exp_size_in;
         exp_chunks_ff <= exp_chunks_in;
         seen_ff       <= seen_in;
         cnt_ff        <= cnt_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CBR_ASSERT_NEXT(a_begin_ack, start && !busy && req_data.req_type == REQ_BEGIN, rsp_valid && rsp_data.result_kind == KIND_BEGIN, "begin transfer not acknowledged in the next cycle")
   `CBR_ASSERT_SAME(a_ack_status, rsp_valid && rsp_data.result_kind != KIND_COMMIT, rsp_data.commit_status == STAT_OK, "chunk or begin ack carries a commit status")
   `CBR_ASSERT_SAME(a_commit_acc, rsp_valid && rsp_data.result_kind == KIND_COMMIT, !rsp_data.accepted, "commit status flagged as accepted")
   `CBR_ASSERT_SAME(a_hash_no_wr, state_ff == ST_HASH, !mem_we, "buffer written during the hash pass")

endmodule
